[rtl/idle_gap_packet_receiver_top_assert.svh]
// assertion macros for the packet receiver rtl
// expects clk and rst_n in the scope of the module that uses them
`ifndef IDLE_GAP_PACKET_RECEIVER_TOP_ASSERT_SVH
`define IDLE_GAP_PACKET_RECEIVER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define IGPR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define IGPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/igpr_pkg.sv]
// shared types and constants for the idle gap packet receiver
// no dependencies
`timescale 1ns / 1ps

package igpr_pkg;

    // packet store geometry
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int DATA_W      = 8;
    localparam int LEN_W       = 6;

    // tick counters
    localparam int           TICK_W      = 16;
    localparam logic [15:0]  TICK_SAT    = 16'hFFFE;
    localparam logic [15:0]  RD_THR_RST  = 16'd20;
    localparam logic [15:0]  GAP_THR_RST = 16'd100;

    // input word opcodes
    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,
        OP_TICK = 2'd1,
        OP_READ = 2'd2
    } op_t;

    // configuration register indexes
    localparam logic REG_READ_IDLE  = 1'b0;
    localparam logic REG_PACKET_GAP = 1'b1;

    // read launch from the ingest logic to the read sequencer
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] len;
    } rd_start_t;

    // sequencer status back to the ingest logic
    typedef struct packed {
        logic busy;
    } seq_stat_t;

endpackage

[rtl/igpr_byte_ram.sv]
// generic simple dual-port ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module igpr_byte_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/igpr_rd_seq.sv]
// read sequencer: streams a packet out of the byte store, one word a cycle while out_ready is high
// depends on igpr_pkg
`timescale 1ns / 1ps

module igpr_rd_seq
    import igpr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  rd_start_t         start,
    input  logic [DATA_W-1:0] ram_q,
    output logic              ram_re,
    output logic [ADDR_W-1:0] ram_raddr,
    output seq_stat_t         stat,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] data_byte,
    output logic [LEN_W-1:0]  packet_length,
    output logic              has_data,
    output logic              is_last
);

    logic              active_reg, active_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ADDR_W-1:0] len_reg, len_next;
    logic              valid_reg, valid_next;
    logic              has_reg, has_next;
    logic              last_reg, last_next;
    logic              adv;
    logic [ADDR_W-1:0] idx_inc;

    // issue a store read whenever the output register is free next cycle
    assign adv     = active_reg && (!valid_reg || out_ready);
    assign idx_inc = idx_reg + 1'b1;

    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        len_next    = len_reg;
        valid_next  = valid_reg;
        has_next    = has_reg;
        last_next   = last_reg;
        if (start.valid)
        begin
            // a read with nothing to return gives a single empty word
            if (start.len == '0)
            begin
                valid_next = 1'b1;
                has_next   = 1'b0;
                last_next  = 1'b1;
            end
            else
            begin
                active_next = 1'b1;
                idx_next    = '0;
                len_next    = start.len;
            end
        end
        else if (adv)
        begin
            idx_next    = idx_inc;
            active_next = (idx_inc != len_reg);
            valid_next  = 1'b1;
            has_next    = 1'b1;
            last_next   = (idx_inc == len_reg);
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        len_reg  <= len_next;
        has_reg  <= has_next;
        last_reg <= last_next;
    end

    assign ram_re        = adv;
    assign ram_raddr     = idx_reg;
    assign stat.busy     = active_reg || valid_reg;
    assign out_valid     = valid_reg;
    assign has_data      = has_reg;
    assign is_last       = last_reg;
    assign data_byte     = has_reg ? ram_q : '0;
    assign packet_length = has_reg ? LEN_W'(len_reg) : '0;

endmodule

[rtl/idle_gap_packet_receiver_top.sv]
// Idle gap packet receiver: collects good serial bytes into a 64-entry byte
// store and frames packets by idle gaps counted in tick words. Byte, tick
// and configuration words are accepted back to back. A read word returning
// N bytes keeps the input closed until its last result is taken: N result
// words, one per cycle while out_ready stays high, paced by the single read
// port of the byte store; an early or empty read gives one empty result
// word. There is no clearing pass after reset.
// depends on igpr_pkg, igpr_byte_ram, igpr_rd_seq and the assertion header
`timescale 1ns / 1ps

`include "idle_gap_packet_receiver_top_assert.svh"

module idle_gap_packet_receiver_top
    import igpr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          opcode,
    input  logic [DATA_W-1:0]   rx_byte,
    input  logic                rx_error,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [DATA_W-1:0]   data_byte,
    output logic [LEN_W-1:0]    packet_length,
    output logic                has_data,
    output logic                is_last,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [TICK_W-1:0]   cfg_data
);

    logic [TICK_W-1:0] rd_thr_reg, gap_thr_reg;
    logic [TICK_W-1:0] idle_reg, idle_next;
    logic [TICK_W-1:0] gap_reg, gap_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              full_reg, full_next;
    logic              in_acc;
    logic              restart;
    logic [CNT_W-1:0]  base;
    logic              room;
    logic              read_ok;
    logic [ADDR_W-1:0] rd_len;
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_q;
    rd_start_t         start;
    seq_stat_t         stat;

    assign in_ready = !stat.busy;
    assign in_acc   = in_valid && in_ready;

    // byte placement and read length
    assign restart = gap_reg > gap_thr_reg;
    assign base    = restart ? '0 : count_reg;
    assign room    = !full_reg && (base < CNT_W'(STORE_DEPTH));
    assign read_ok = idle_reg > rd_thr_reg;
    assign rd_len  = (count_reg >= CNT_W'(STORE_DEPTH - 1)) ? ADDR_W'(STORE_DEPTH - 1)
                                                           : count_reg[ADDR_W-1:0];

    // word decode and state update
    always_comb
    begin
        idle_next   = idle_reg;
        gap_next    = gap_reg;
        count_next  = count_reg;
        full_next   = full_reg;
        ram_we      = 1'b0;
        start.valid = 1'b0;
        start.len   = '0;
        if (in_acc)
        begin
            case (op_t'(opcode))
                OP_BYTE:
                begin
                    if (!rx_error)
                    begin
                        idle_next  = '0;
                        gap_next   = TICK_W'(1);
                        count_next = base;
                        if (room)
                        begin
                            ram_we     = 1'b1;
                            count_next = base + 1'b1;
                        end
                        if (!full_reg && (count_next >= CNT_W'(STORE_DEPTH)))
                        begin
                            full_next = 1'b1;
                        end
                    end
                end
                OP_TICK:
                begin
                    if (idle_reg < TICK_SAT)
                    begin
                        idle_next = idle_reg + 1'b1;
                    end
                    if (gap_reg < TICK_SAT)
                    begin
                        gap_next = gap_reg + 1'b1;
                    end
                end
                OP_READ:
                begin
                    start.valid = 1'b1;
                    if (read_ok)
                    begin
                        start.len  = rd_len;
                        count_next = '0;
                        full_next  = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_reg  <= '0;
            gap_reg   <= '0;
            count_reg <= '0;
            full_reg  <= 1'b0;
        end
        else
        begin
            idle_reg  <= idle_next;
            gap_reg   <= gap_next;
            count_reg <= count_next;
            full_reg  <= full_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_thr_reg  <= RD_THR_RST;
            gap_thr_reg <= GAP_THR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_READ_IDLE:  rd_thr_reg  <= cfg_data;
                REG_PACKET_GAP: gap_thr_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // byte store
    igpr_byte_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (base[ADDR_W-1:0]),
        .wdata (rx_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    // packet readout
    igpr_rd_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .ram_q         (ram_q),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .stat          (stat),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .data_byte     (data_byte),
        .packet_length (packet_length),
        .has_data      (has_data),
        .is_last       (is_last)
    );

    // checks
    `IGPR_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CNT_W'(STORE_DEPTH), "byte count past store depth")
    `IGPR_ASSERT_NOW(a_idle_sat, 1'b1, idle_reg <= TICK_SAT, "idle counter past saturation")
    `IGPR_ASSERT_NEXT(a_good_byte, in_acc && (opcode == OP_BYTE) && !rx_error, (idle_reg == '0) && (gap_reg == TICK_W'(1)), "good byte did not reset counters")
    `IGPR_ASSERT_NEXT(a_read_empties, in_acc && (opcode == OP_READ) && read_ok, (count_reg == '0) && !full_reg, "accepted read left store occupied")
    `IGPR_ASSERT_NOW(a_len_nonzero, out_valid && has_data, packet_length != '0, "data word with zero packet length")

endmodule

[tb/idle_gap_packet_receiver_top_test.sv]
// self-checking testbench for idle_gap_packet_receiver_top: framing predictor,
// valid/ready driver and monitor with random idling, register write phases
// depends on igpr_pkg and the idle_gap_packet_receiver_top rtl
`timescale 1ns / 1ps

module idle_gap_packet_receiver_top_test;
    import igpr_pkg::*;

    // opcode value outside the defined set, the block ignores it
    localparam logic [1:0] OP_SPARE    = 2'd3;
    localparam int         CYCLE_LIMIT = 3000000;
    localparam int         DRAIN_PAUSE = 16;
    localparam int         LONG_HOLD   = 400;

    typedef struct packed {
        logic [1:0]        op;
        logic [DATA_W-1:0] value;
        logic              err;
    } rx_word_t;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic              has;
        logic              last;
    } reply_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic                in_ready;
    logic [1:0]          opcode        = '0;
    logic [DATA_W-1:0]   rx_byte       = '0;
    logic                rx_error      = 1'b0;
    logic                out_valid;
    logic                out_ready     = 1'b0;
    logic [DATA_W-1:0]   data_byte;
    logic [LEN_W-1:0]    packet_length;
    logic                has_data;
    logic                is_last;
    logic                cfg_we        = 1'b0;
    logic                cfg_index     = 1'b0;
    logic [TICK_W-1:0]   cfg_data      = '0;

    // stimulus and scoreboard state
    rx_word_t    tx_words[$];
    reply_t      owed_replies[$];
    int unsigned words_queued  = 0;
    int unsigned replies_seen  = 0;
    int unsigned mismatches    = 0;
    int unsigned cycle_count   = 0;
    logic        in_taken      = 1'b0;
    logic        calm          = 1'b0;

    // framing predictor state
    logic [DATA_W-1:0] pkt_store [STORE_DEPTH];
    logic [6:0]        byte_count = '0;
    logic [15:0]       idle_ticks = '0;
    logic [15:0]       gap_ticks  = '0;
    logic              full_latch = 1'b0;
    logic [15:0]       rd_thr     = RD_THR_RST;
    logic [15:0]       gap_thr    = GAP_THR_RST;

    idle_gap_packet_receiver_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .rx_byte       (rx_byte),
        .rx_error      (rx_error),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .data_byte     (data_byte),
        .packet_length (packet_length),
        .has_data      (has_data),
        .is_last       (is_last),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // apply one accepted word to the framing state, owing any read replies
    task automatic track_framing(input logic [1:0] op, input logic [DATA_W-1:0] value,
                                 input logic err);
        int     n;
        reply_t r;
        n = 0;
        case (op)
            OP_BYTE:
            begin
                if (!err)
                begin
                    idle_ticks = '0;
                    if (gap_ticks > gap_thr)
                        byte_count = '0;
                    gap_ticks = 16'd1;
                    if (!full_latch)
                    begin
                        if (byte_count < STORE_DEPTH)
                        begin
                            pkt_store[byte_count[ADDR_W-1:0]] = value;
                            byte_count = byte_count + 7'd1;
                        end
                        if (byte_count >= STORE_DEPTH)
                            full_latch = 1'b1;
                    end
                end
            end
            OP_TICK:
            begin
                if (idle_ticks < TICK_SAT)
                    idle_ticks = idle_ticks + 16'd1;
                if (gap_ticks < TICK_SAT)
                    gap_ticks = gap_ticks + 16'd1;
            end
            OP_READ:
            begin
                if (idle_ticks > rd_thr)
                begin
                    n = (byte_count > STORE_DEPTH - 1) ? STORE_DEPTH - 1 : int'(byte_count);
                    byte_count = '0;
                    full_latch = 1'b0;
                end
                if (n == 0)
                begin
                    r = '{data: '0, len: '0, has: 1'b0, last: 1'b1};
                    owed_replies.push_back(r);
                end
                for (int i = 0; i < n; i++)
                begin
                    r.data = pkt_store[i];
                    r.len  = n[LEN_W-1:0];
                    r.has  = 1'b1;
                    r.last = (i == n - 1);
                    owed_replies.push_back(r);
                end
            end
            default: ;
        endcase
    endtask

    task automatic flag_mismatch(input string what, input reply_t want, input reply_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: want %02h/%0d/%0b/%0b got %02h/%0d/%0b/%0b",
                     $realtime, what, want.data, want.len, want.has, want.last,
                     got.data, got.len, got.has, got.last);
    endtask

    // accepted input words feed the predictor, accepted results are checked
    always @(posedge clk)
    begin : scoreboard_p
        reply_t got;
        reply_t want;
        in_taken <= in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                track_framing(opcode, rx_byte, rx_error);
            if (out_valid && out_ready)
            begin
                got = '{data: data_byte, len: packet_length, has: has_data, last: is_last};
                replies_seen++;
                if (owed_replies.size() == 0)
                    flag_mismatch("unexpected result", '0, got);
                else
                begin
                    want = owed_replies.pop_front();
                    if (got.data !== want.data || got.len !== want.len ||
                        got.has !== want.has || got.last !== want.last)
                        flag_mismatch("mismatch", want, got);
                end
            end
        end
    end

    // input driver with random idle bursts
    always @(negedge clk)
    begin : driver_p
        int unsigned send_hold;
        rx_word_t    w;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !in_taken)
            ;
        else if (send_hold > 0)
        begin
            send_hold--;
            in_valid <= 1'b0;
        end
        else if (!calm && tx_words.size() > 0 && $urandom_range(0, 4) == 0)
        begin
            send_hold = $urandom_range(0, 4);
            in_valid <= 1'b0;
        end
        else if (tx_words.size() > 0)
        begin
            w = tx_words.pop_front();
            opcode   <= w.op;
            rx_byte  <= w.value;
            rx_error <= w.err;
            in_valid <= 1'b1;
        end
        else
            in_valid <= 1'b0;
    end

    // result ready with random stalls and one long hold-off
    always @(negedge clk)
    begin : ready_p
        int unsigned ready_hold;
        bit          long_done;
        if (ready_hold > 0)
        begin
            ready_hold--;
            out_ready <= 1'b0;
        end
        else if (!long_done && replies_seen >= 60)
        begin
            long_done  = 1'b1;
            ready_hold = LONG_HOLD - 1;
            out_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            ready_hold = $urandom_range(0, 4);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ignored words do not count toward the stimulus target
    task automatic queue_word(input logic [1:0] op, input logic [DATA_W-1:0] value,
                              input logic err);
        tx_words.push_back('{op: op, value: value, err: err});
        if (op != OP_SPARE && !(op == OP_BYTE && err))
            words_queued++;
    endtask

    task automatic queue_ticks(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            queue_word(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // wait for the block to go quiet before touching registers
    task automatic finish_phase();
        while (tx_words.size() != 0 || in_valid || owed_replies.size() != 0)
            @(negedge clk);
        repeat (DRAIN_PAUSE) @(negedge clk);
    endtask

    // write both thresholds, called at a falling edge while idle
    task automatic set_thresholds(input logic [15:0] rd, input logic [15:0] gap);
        cfg_we    <= 1'b1;
        cfg_index <= REG_READ_IDLE;
        cfg_data  <= rd;
        @(negedge clk);
        cfg_index <= REG_PACKET_GAP;
        cfg_data  <= gap;
        @(negedge clk);
        cfg_we    <= 1'b0;
        rd_thr  = rd;
        gap_thr = gap;
    endtask

    // mostly complete packets with random content, plus noise and broken framing
    task automatic random_traffic(input int unsigned target);
        int unsigned goal;
        int unsigned kind;
        int unsigned len;
        goal = words_queued + target;
        while (words_queued < goal)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 70)
                                                   : $urandom_range(1, 10);
                for (int unsigned i = 0; i < len; i++)
                begin
                    // occasional gap inside the packet restarts it
                    if ($urandom_range(0, 19) == 0)
                        queue_ticks(gap_thr + 1);
                    queue_word(OP_BYTE, 8'($urandom_range(0, 255)),
                               $urandom_range(0, 9) == 0);
                end
                // sometimes exactly at the threshold, so the read comes too early
                queue_ticks(($urandom_range(0, 4) == 0) ? rd_thr
                                                        : rd_thr + 1 + $urandom_range(0, 1));
                queue_word(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            else if (kind == 6)
            begin
                len = $urandom_range(1, 6);
                for (int unsigned i = 0; i < len; i++)
                    queue_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1)));
            end
            else if (kind == 7)
            begin
                len = $urandom_range(1, 4);
                for (int unsigned i = 0; i < len; i++)
                    queue_word(OP_BYTE, 8'($urandom_range(0, 255)), 1'b0);
                queue_word(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            else if (kind == 8)
            begin
                // fill the store, then a restart that cannot store
                for (int unsigned i = 0; i < 65; i++)
                    queue_word(OP_BYTE, 8'($urandom_range(0, 255)), 1'b0);
                queue_ticks(gap_thr + 1);
                queue_word(OP_BYTE, 8'($urandom_range(0, 255)), 1'b0);
                queue_ticks(rd_thr + 1);
                queue_word(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            else
            begin
                queue_ticks(rd_thr + 1);
                queue_word(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // stimulus sequence
    initial
    begin
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset thresholds: early reads, extremes, discarded and ignored words
        queue_word(OP_READ, 8'h00, 1'b0);
        queue_word(OP_BYTE, 8'h00, 1'b0);
        queue_word(OP_BYTE, 8'hFF, 1'b0);
        queue_word(OP_BYTE, 8'hA5, 1'b1);
        queue_word(OP_SPARE, 8'h5A, 1'b1);
        queue_word(OP_READ, 8'hFF, 1'b1);
        finish_phase();

        // small thresholds: accepted read, empty accepted read, gap restart
        set_thresholds(16'd2, 16'd3);
        queue_ticks(3);
        queue_word(OP_READ, 8'h00, 1'b0);
        queue_word(OP_READ, 8'h00, 1'b0);
        queue_word(OP_BYTE, 8'h3C, 1'b0);
        queue_ticks(4);
        queue_word(OP_BYTE, 8'hC3, 1'b0);
        queue_ticks(3);
        queue_word(OP_READ, 8'h00, 1'b0);
        queue_word(OP_BYTE, 8'h81, 1'b0);
        queue_ticks(1);
        queue_word(OP_READ, 8'h00, 1'b0);
        queue_ticks(2);
        queue_word(OP_READ, 8'h00, 1'b0);
        finish_phase();

        set_thresholds(16'd0, 16'd0);
        random_traffic(80);
        finish_phase();

        set_thresholds(16'd3, 16'd6);
        random_traffic(130);
        finish_phase();

        set_thresholds(16'hFFFF, 16'hFFFF);
        queue_word(OP_BYTE, 8'h55, 1'b0);
        queue_ticks(3);
        queue_word(OP_READ, 8'h00, 1'b0);
        finish_phase();

        set_thresholds(16'($urandom_range(0, 4)), 16'($urandom_range(0, 9)));
        random_traffic(130);
        finish_phase();

        // last stretch without idling on either side
        calm = 1'b1;
        set_thresholds(16'd1, 16'd10);
        random_traffic(70);
        finish_phase();

        if (mismatches == 0 && owed_replies.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[idle_gap_packet_receiver_top.f]
+incdir+rtl
rtl/igpr_pkg.sv
rtl/igpr_byte_ram.sv
rtl/igpr_rd_seq.sv
rtl/idle_gap_packet_receiver_top.sv
tb/idle_gap_packet_receiver_top_test.sv
